FILE: sv/mrf_pkg.sv
// shared types, constants and crc helper for the modbus rtu request framer
// depends on nothing; the front, queue, back and top files use it by scoped names
package mrf_pkg;

    // command codes of the input transaction
    localparam logic [2:0] CMD_READ_REGS   = 3'd0;
    localparam logic [2:0] CMD_WRITE_REG   = 3'd1;
    localparam logic [2:0] CMD_LOOPBACK    = 3'd2;
    localparam logic [2:0] CMD_MULTI_HDR   = 3'd3;
    localparam logic [2:0] CMD_MULTI_VALUE = 3'd4;

    // modbus function codes
    localparam logic [7:0] FC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FC_DIAGNOSTIC   = 8'h08;
    localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;

    // register count limits for write multiple
    localparam logic [6:0] MAX_REGISTERS = 7'd123;
    localparam logic [6:0] MIN_REGISTERS = 7'd1;

    // crc-16 modbus
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // byte counts of the job descriptors
    localparam int          JOB_MAX_BYTES = 7;
    localparam logic [2:0]  NB_SHORT      = 3'd2;
    localparam logic [2:0]  NB_SINGLE     = 3'd6;
    localparam logic [2:0]  NB_HEADER     = 3'd7;

    // job queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // one job: data bytes in frame order plus crc handling
    typedef struct packed {
        logic [JOB_MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                    nbytes;
        logic                          restart;
        logic                          emit_crc;
    } t_job;

    // queue status seen by the producer and the consumer
    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_status;

    // fold one byte into the crc, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: sv/mrf_if.sv
// valid/ready channel interfaces for command input and frame byte output
// depends on nothing
interface mrf_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [7:0]  slave_address;
    logic [15:0] register_address;
    logic [15:0] data_word;
    logic [6:0]  register_count;

    modport source (output valid, output command, output slave_address,
                    output register_address, output data_word,
                    output register_count, input ready);
    modport sink   (input valid, input command, input slave_address,
                    input register_address, input data_word,
                    input register_count, output ready);
endinterface

interface mrf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

FILE: sv/mrf_front.sv
// front end: accepts commands, tracks the open multi-write frame, builds jobs
// depends on mrf_pkg and mrf_cmd_if
module mrf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mrf_cmd_if.sink              i_cmd,
    input  mrf_pkg::t_fifo_status i_fifo_status,
    output logic                 o_push,
    output mrf_pkg::t_job        o_job
);

    logic [6:0] r_words_left;
    logic [6:0] n_words_left;
    logic [6:0] cnt_sat;
    logic       accept;

    assign i_cmd.ready = !i_fifo_status.full;
    assign accept      = i_cmd.valid && i_cmd.ready;

    // clamp the register count into the legal range
    always_comb begin
        if (i_cmd.register_count > mrf_pkg::MAX_REGISTERS) begin
            cnt_sat = mrf_pkg::MAX_REGISTERS;
        end else if (i_cmd.register_count == 7'd0) begin
            cnt_sat = mrf_pkg::MIN_REGISTERS;
        end else begin
            cnt_sat = i_cmd.register_count;
        end
    end

    // classify the command and build the job descriptor
    always_comb begin
        o_push       = 1'b0;
        o_job        = '0;
        n_words_left = r_words_left;
        case (i_cmd.command)
            mrf_pkg::CMD_READ_REGS, mrf_pkg::CMD_WRITE_REG: begin
                o_push         = accept;
                o_job.bytes[0] = i_cmd.slave_address;
                o_job.bytes[1] = (i_cmd.command == mrf_pkg::CMD_READ_REGS) ?
                                 mrf_pkg::FC_READ_HOLDING : mrf_pkg::FC_WRITE_SINGLE;
                o_job.bytes[2] = i_cmd.register_address[15:8];
                o_job.bytes[3] = i_cmd.register_address[7:0];
                o_job.bytes[4] = i_cmd.data_word[15:8];
                o_job.bytes[5] = i_cmd.data_word[7:0];
                o_job.nbytes   = mrf_pkg::NB_SINGLE;
                o_job.restart  = 1'b1;
                o_job.emit_crc = 1'b1;
                n_words_left   = 7'd0;
            end
            mrf_pkg::CMD_LOOPBACK: begin
                o_push         = accept;
                o_job.bytes[0] = i_cmd.slave_address;
                o_job.bytes[1] = mrf_pkg::FC_DIAGNOSTIC;
                o_job.nbytes   = mrf_pkg::NB_SHORT;
                o_job.restart  = 1'b1;
                o_job.emit_crc = 1'b1;
                n_words_left   = 7'd0;
            end
            mrf_pkg::CMD_MULTI_HDR: begin
                o_push         = accept;
                o_job.bytes[0] = i_cmd.slave_address;
                o_job.bytes[1] = mrf_pkg::FC_WRITE_MULTI;
                o_job.bytes[2] = i_cmd.register_address[15:8];
                o_job.bytes[3] = i_cmd.register_address[7:0];
                o_job.bytes[4] = 8'h00;
                o_job.bytes[5] = {1'b0, cnt_sat};
                o_job.bytes[6] = {cnt_sat, 1'b0};
                o_job.nbytes   = mrf_pkg::NB_HEADER;
                o_job.restart  = 1'b1;
                o_job.emit_crc = 1'b0;
                n_words_left   = cnt_sat;
            end
            mrf_pkg::CMD_MULTI_VALUE: begin
                // value with no open frame is dropped
                o_push         = accept && (r_words_left != 7'd0);
                o_job.bytes[0] = i_cmd.data_word[15:8];
                o_job.bytes[1] = i_cmd.data_word[7:0];
                o_job.nbytes   = mrf_pkg::NB_SHORT;
                o_job.restart  = 1'b0;
                o_job.emit_crc = (r_words_left == 7'd1);
                if (r_words_left != 7'd0) begin
                    n_words_left = r_words_left - 7'd1;
                end
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    // open frame word counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words_left <= 7'd0;
        end else if (accept) begin
            r_words_left <= n_words_left;
        end
    end

endmodule

FILE: sv/mrf_fifo.sv
// short job queue that decouples the front end from the byte sequencer
// depends on mrf_pkg
module mrf_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  mrf_pkg::t_job         i_job,
    input  logic                  i_pop,
    output mrf_pkg::t_job         o_job,
    output mrf_pkg::t_fifo_status o_status
);

    mrf_pkg::t_job                  r_mem [mrf_pkg::FIFO_DEPTH];
    logic [mrf_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [mrf_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [mrf_pkg::FIFO_CNT_W-1:0] r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == mrf_pkg::FIFO_CNT_W'(mrf_pkg::FIFO_DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_job          = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: sv/mrf_back.sv
// back end: plays each job out one byte per cycle while the output is ready,
// folds in the crc, appends it if emit_crc; depends on mrf_pkg and mrf_byte_if
module mrf_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mrf_pkg::t_job         i_job,
    input  mrf_pkg::t_fifo_status i_fifo_status,
    output logic                  o_pop,
    mrf_byte_if.source            o_frame
);

    mrf_pkg::t_job r_job, n_job;
    logic [3:0]    r_idx, n_idx;
    logic          r_busy, n_busy;
    logic [15:0]   r_crc, n_crc;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_byte, n_out_byte;
    logic          r_out_last, n_out_last;

    logic          advance;
    logic          step;
    logic          cur_final;
    logic [3:0]    nb_ext;
    logic [7:0]    data_byte;

    assign nb_ext    = {1'b0, r_job.nbytes};
    assign advance   = !r_out_valid || o_frame.ready;
    assign step      = advance && r_busy;
    assign cur_final = r_job.emit_crc ? (r_idx == nb_ext + 4'd1) : (r_idx == nb_ext - 4'd1);
    assign o_pop     = !i_fifo_status.empty && (!r_busy || (step && cur_final));
    assign data_byte = r_job.bytes[r_idx[2:0]];

    assign o_frame.valid      = r_out_valid;
    assign o_frame.frame_byte = r_out_byte;
    assign o_frame.last_byte  = r_out_last;

    // byte sequencer
    always_comb begin
        n_job       = r_job;
        n_idx       = r_idx;
        n_busy      = r_busy;
        n_crc       = r_crc;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        if (step) begin
            n_out_valid = 1'b1;
            n_idx       = r_idx + 4'd1;
            if (r_idx < nb_ext) begin
                n_out_byte = data_byte;
                n_out_last = 1'b0;
                n_crc      = mrf_pkg::crc_byte(r_crc, data_byte);
            end else if (r_idx == nb_ext) begin
                n_out_byte = r_crc[7:0];
                n_out_last = 1'b0;
            end else begin
                n_out_byte = r_crc[15:8];
                n_out_last = 1'b1;
            end
            if (cur_final) begin
                n_busy = 1'b0;
                if (r_job.emit_crc) begin
                    n_crc = mrf_pkg::CRC_INIT;
                end
            end
        end else if (advance) begin
            n_out_valid = 1'b0;
        end

        // take the next job from the queue
        if (o_pop) begin
            n_job  = i_job;
            n_busy = 1'b1;
            n_idx  = 4'd0;
            if (i_job.restart) begin
                n_crc = mrf_pkg::CRC_INIT;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 4'd0;
            r_crc       <= mrf_pkg::CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_job      <= n_job;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

endmodule

FILE: sv/modbus_rtu_request_framer.sv
// Modbus RTU request framer: each command transaction becomes the bytes of a
// request frame (03, 06, 08 or a 16 built over a header and value items),
// closed by the CRC-16, low byte first, with last_byte on the final byte.
// One frame byte leaves per cycle while ready is high, from a registered
// output; a transaction yields 0 to 8 bytes, so a stream of 03 or 06 requests
// is paced by the one-byte-per-cycle sequencer in the back end.
// A two-entry job queue lets commands be accepted while earlier frames drain;
// an idle gap is added only when the sequencer starts from empty.
// depends on mrf_pkg, mrf_if, mrf_front, mrf_fifo and mrf_back
module modbus_rtu_request_framer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mrf_cmd_if.sink    i_cmd,
    mrf_byte_if.source o_frame
);

    logic                  push;
    logic                  pop;
    mrf_pkg::t_job         push_job;
    mrf_pkg::t_job         head_job;
    mrf_pkg::t_fifo_status fifo_status;

    // command classification
    mrf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (i_cmd),
        .i_fifo_status (fifo_status),
        .o_push        (push),
        .o_job         (push_job)
    );

    // job queue
    mrf_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (fifo_status)
    );

    // byte sequencer and crc
    mrf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (head_job),
        .i_fifo_status (fifo_status),
        .o_pop         (pop),
        .o_frame       (o_frame)
    );

endmodule
